/* src/cnm_pkg.sv */
`default_nettype none

package cnm_pkg;

  // node status codes
  localparam logic [1:0] ST_DISABLED  = 2'd0;
  localparam logic [1:0] ST_RECOVERY  = 2'd1;
  localparam logic [1:0] ST_RECOVERED = 2'd2;
  localparam logic [1:0] ST_ONLINE    = 2'd3;

  // event kinds
  localparam logic [3:0] MODE_NBR_DISABLE        = 4'd0;
  localparam logic [3:0] MODE_NBR_RECEIVER_START = 4'd1;
  localparam logic [3:0] MODE_NBR_SENDER_RECOV   = 4'd2;
  localparam logic [3:0] MODE_NBR_SENDER_DONE    = 4'd3;
  localparam logic [3:0] MODE_NBR_CAUGHTUP       = 4'd4;
  localparam logic [3:0] MODE_SELF_DISABLE       = 4'd5;
  localparam logic [3:0] MODE_RECOVERY_FINISH    = 4'd6;
  localparam logic [3:0] MODE_RECHECK            = 4'd7;
  localparam logic [3:0] MODE_CONNECT            = 4'd8;
  localparam logic [3:0] MODE_DISCONNECT         = 4'd9;

  // configuration register indexes
  localparam logic [2:0] REG_NODE_COUNT    = 3'd0;
  localparam logic [2:0] REG_SELF_ID       = 3'd1;
  localparam logic [2:0] REG_HALF_GRANT    = 3'd2;
  localparam logic [2:0] REG_CLIQUE_MASK   = 3'd3;
  localparam logic [2:0] REG_STOPPED_MASK  = 3'd4;
  localparam logic [2:0] REG_SAVED_WINNER  = 3'd5;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef struct packed {
    logic [3:0] mode;
    logic [4:0] node_id;
  } cnm_event_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] disabled_nodes;
    logic [31:0] recovery_count;
    logic [4:0]  resolve_node;
    logic        resolve_all;
    logic [4:0]  referee_winner;
  } cnm_result_t;

endpackage

`default_nettype wire

/* src/cnm_ones.sv */
`default_nettype none

// counts the set bits among the lowest 'limit' positions of a mask
module cnm_ones #(
  parameter int WIDTH = 16,
  parameter int CW    = 5
) (
  input  wire logic [WIDTH-1:0] bits,
  input  wire logic [CW-1:0]    limit,
  output logic      [CW-1:0]    count
);

  // per-position enable from the node limit, then a plain count
  always_comb begin
    count = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (i < int'(limit) && bits[i]) begin
        count = count + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/cluster_node_membership_fsm_core.sv */
`default_nettype none

// Quorum status machine for one node of a replicated cluster.
// Event channel: event_valid / event_stall / event_word (mode, node_id).
// Result channel: result_valid / result_stall / result_word, one result word
// per event word, in order.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// indexes beyond the register list are ignored. Write only
// while no event is in flight.
// Path: an accepted event sits in the input register, then moves to the
// result register, from which the result word is taken.
// Throughput: one event per cycle while no result is held by result_stall;
// the whole update, population counts and status chain settle between the
// input register and the result register, and the state registers are
// written at the same edge as the result, so the next event sees them.
// Stall: while a result is held by result_stall the input register holds
// too, and event_stall is high while that input register is occupied.
// Reset (rst, synchronous): status disabled, all masks, flag, counter and
// winner cleared, configuration to its defaults, both channels empty.
module cluster_node_membership_fsm_core
  import cnm_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  event_valid,
  output logic                       event_stall,
  input  wire cnm_event_t            event_word,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output cnm_result_t                result_word,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int WW = MAX_NODES + 64;

  // one-hot bit of a one-based node id, zero when the id has no bit
  function automatic logic [MAX_NODES-1:0] id_bit(input logic [4:0] id);
    logic [MAX_NODES-1:0] v;
    v = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (int'(id) == i + 1) begin
        v[i] = 1'b1;
      end
    end
    return v;
  endfunction

  // a 16-bit configuration mask fitted to the node width
  function automatic logic [MAX_NODES-1:0] fit_mask(input logic [15:0] m);
    logic [WW-1:0] w;
    w = WW'(m);
    return w[MAX_NODES-1:0];
  endfunction

  // configuration registers
  logic [4:0]  node_count;
  logic [4:0]  self_id;
  logic        half_grant;
  logic [15:0] clique_mask;
  logic [15:0] stopped_mask;
  logic [4:0]  saved_winner_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= 5'd3;
      self_id         <= 5'd1;
      half_grant      <= 1'b0;
      clique_mask     <= 16'hffff;
      stopped_mask    <= 16'h0000;
      saved_winner_id <= 5'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NODE_COUNT:    node_count      <= cfg_data[4:0];
        REG_SELF_ID:       self_id         <= cfg_data[4:0];
        REG_HALF_GRANT:    half_grant      <= cfg_data[0];
        REG_CLIQUE_MASK:   clique_mask     <= cfg_data;
        REG_STOPPED_MASK:  stopped_mask    <= cfg_data;
        REG_SAVED_WINNER:  saved_winner_id <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // membership state
  logic [1:0]           status;
  logic [MAX_NODES-1:0] disabled_set;
  logic [MAX_NODES-1:0] unreachable_set;
  logic [MAX_NODES-1:0] receiver_set;
  logic [MAX_NODES-1:0] sender_set;
  logic                 recovered_flag;
  logic [31:0]          restart_counter;
  logic [4:0]           winner_node;

  // input register and handshake
  logic       s1_valid;
  cnm_event_t s1_word;
  logic       advance;

  assign advance     = s1_valid && !(result_valid && result_stall);
  assign event_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!event_stall) begin
      s1_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!event_stall && event_valid) begin
      s1_word <= event_word;
    end
  end

  // decoded ids and configuration views
  logic [MAX_NODES-1:0] ev_bit;
  logic [MAX_NODES-1:0] me;
  logic [MAX_NODES-1:0] clique_w;
  logic [MAX_NODES-1:0] stopped_w;
  logic [CW-1:0]        n_eff;
  logic [CW-1:0]        half;

  assign ev_bit    = id_bit(s1_word.node_id);
  assign me        = id_bit(self_id);
  assign clique_w  = fit_mask(clique_mask);
  assign stopped_w = fit_mask(stopped_mask);
  assign half      = n_eff >> 1;

  always_comb begin
    if (int'(node_count) < MAX_NODES) begin
      n_eff = CW'(node_count);
    end else begin
      n_eff = CW'(MAX_NODES);
    end
  end

  // event phase: mask, flag and counter updates ahead of the status check
  logic [MAX_NODES-1:0] ev_dis;
  logic [MAX_NODES-1:0] ev_unr;
  logic [MAX_NODES-1:0] ev_rcv;
  logic [MAX_NODES-1:0] ev_snd;
  logic                 ev_flag;
  logic                 ev_inc;
  logic [4:0]           ev_resolve;
  logic                 do_check;
  logic                 dis_hit;

  assign dis_hit = (ev_bit != '0) && ((disabled_set & ev_bit) == '0);

  always_comb begin
    ev_dis     = disabled_set;
    ev_unr     = unreachable_set;
    ev_rcv     = receiver_set;
    ev_snd     = sender_set;
    ev_flag    = recovered_flag;
    ev_inc     = 1'b0;
    ev_resolve = 5'd0;
    do_check   = 1'b0;
    unique case (s1_word.mode) inside
      MODE_NBR_DISABLE, MODE_NBR_SENDER_RECOV: begin
        if (dis_hit) begin
          ev_dis = disabled_set | ev_bit;
          if (status == ST_ONLINE) begin
            ev_resolve = s1_word.node_id;
          end
        end
        do_check = 1'b1;
      end
      MODE_NBR_RECEIVER_START: begin
        ev_rcv   = receiver_set | ev_bit;
        do_check = 1'b1;
      end
      MODE_NBR_SENDER_DONE: begin
        ev_snd   = sender_set | ev_bit;
        ev_dis   = disabled_set & ~ev_bit;
        do_check = 1'b1;
      end
      MODE_NBR_CAUGHTUP, MODE_RECHECK: begin
        do_check = 1'b1;
      end
      MODE_SELF_DISABLE: begin
        ev_dis   = disabled_set | me;
        ev_inc   = 1'b1;
        do_check = 1'b1;
      end
      MODE_RECOVERY_FINISH: begin
        ev_flag  = 1'b1;
        ev_inc   = 1'b1;
        do_check = 1'b1;
      end
      MODE_CONNECT: begin
        ev_unr   = unreachable_set & ~ev_bit;
        do_check = 1'b1;
      end
      MODE_DISCONNECT: begin
        if (ev_bit == '0) begin
          do_check = 1'b1;
        end else if ((unreachable_set & ev_bit) == '0) begin
          ev_unr = unreachable_set | ev_bit;
          if (dis_hit) begin
            ev_dis = disabled_set | ev_bit;
            if (status == ST_ONLINE) begin
              ev_resolve = s1_word.node_id;
            end
          end
          do_check = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // population counts over the first n nodes
  logic [CW-1:0] pop_unr;
  logic [CW-1:0] pop_dis;
  logic [CW-1:0] pop_dis_self;
  logic [CW-1:0] pop_rcv;
  logic [CW-1:0] pop_snd;

  cnm_ones #(.WIDTH(MAX_NODES), .CW(CW)) u_ones_unr (
    .bits(ev_unr), .limit(n_eff), .count(pop_unr)
  );
  cnm_ones #(.WIDTH(MAX_NODES), .CW(CW)) u_ones_dis (
    .bits(ev_dis), .limit(n_eff), .count(pop_dis)
  );
  cnm_ones #(.WIDTH(MAX_NODES), .CW(CW)) u_ones_dis_self (
    .bits(ev_dis & ~me), .limit(n_eff), .count(pop_dis_self)
  );
  cnm_ones #(.WIDTH(MAX_NODES), .CW(CW)) u_ones_rcv (
    .bits(ev_rcv), .limit(n_eff), .count(pop_rcv)
  );
  cnm_ones #(.WIDTH(MAX_NODES), .CW(CW)) u_ones_snd (
    .bits(ev_snd), .limit(n_eff), .count(pop_snd)
  );

  logic [CW-1:0] n_conn;
  logic [CW-1:0] n_en;
  logic [CW-1:0] n_en_self;
  logic          quorum_ok;
  logic          all_synced;

  assign n_conn    = n_eff - pop_unr;
  assign n_en      = n_eff - pop_dis;
  assign n_en_self = n_eff - pop_dis_self;

  assign quorum_ok = ((n_conn >= half + CW'(1)) || ((n_conn == half) && half_grant))
                     && !(((clique_w & me) == '0) && !half_grant)
                     && ((stopped_w & me) == '0);

  assign all_synced = (pop_rcv == n_en) && (pop_snd == n_en)
                      && ({1'b0, n_en} + (CW + 1)'(1) == {1'b0, n_conn});

  // status chain: a failed quorum forces disabled, else disabled -> recovery ->
  // recovered -> online, then the enabled-quorum check of an online node
  logic [1:0]           st_next;
  logic [MAX_NODES-1:0] dis_next;
  logic [MAX_NODES-1:0] rcv_next;
  logic [MAX_NODES-1:0] snd_next;
  logic                 flag_next;
  logic                 chain_inc;
  logic                 res_all;
  logic [4:0]           winner_next;
  logic [CW-1:0]        n_en_cur;
  logic [31:0]          counter_next;

  always_comb begin
    st_next     = status;
    dis_next    = ev_dis;
    rcv_next    = ev_rcv;
    snd_next    = ev_snd;
    flag_next   = ev_flag;
    chain_inc   = 1'b0;
    res_all     = 1'b0;
    winner_next = winner_node;
    n_en_cur    = n_en;
    if (do_check) begin
      if (!quorum_ok) begin
        if (status != ST_DISABLED) begin
          flag_next = 1'b0;
          rcv_next  = '0;
          snd_next  = '0;
          chain_inc = 1'b1;
        end
        dis_next = ev_dis | me;
        st_next  = ST_DISABLED;
      end else begin
        if (st_next == ST_DISABLED) begin
          st_next = ST_RECOVERY;
        end
        if (st_next == ST_RECOVERY && ev_flag) begin
          st_next = ST_RECOVERED;
        end
        if (st_next == ST_RECOVERED && all_synced) begin
          st_next  = ST_ONLINE;
          dis_next = ev_dis & ~me;
          n_en_cur = n_en_self;
          if (!half_grant && saved_winner_id != 5'd0) begin
            res_all     = 1'b1;
            winner_next = saved_winner_id;
          end
        end
        if (st_next == ST_ONLINE &&
            !((n_en_cur >= half + CW'(1)) || ((n_en_cur == half) && half_grant))) begin
          st_next   = ST_DISABLED;
          flag_next = 1'b0;
          rcv_next  = '0;
          snd_next  = '0;
          chain_inc = 1'b1;
          dis_next  = dis_next | me;
        end
      end
    end
  end

  assign counter_next = restart_counter + 32'({1'b0, ev_inc} + {1'b0, chain_inc});

  // state update at the edge that registers the result
  always_ff @(posedge clk) begin
    if (rst) begin
      status          <= ST_DISABLED;
      disabled_set    <= '0;
      unreachable_set <= '0;
      receiver_set    <= '0;
      sender_set      <= '0;
      recovered_flag  <= 1'b0;
      restart_counter <= 32'd0;
      winner_node     <= 5'd0;
    end else if (advance) begin
      status          <= st_next;
      disabled_set    <= dis_next;
      unreachable_set <= ev_unr;
      receiver_set    <= rcv_next;
      sender_set      <= snd_next;
      recovered_flag  <= flag_next;
      restart_counter <= counter_next;
      winner_node     <= winner_next;
    end
  end

  // result register
  logic [WW-1:0] dis_wide;

  assign dis_wide = WW'(dis_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word.status         <= st_next;
      result_word.disabled_nodes <= dis_wide[15:0];
      result_word.recovery_count <= counter_next;
      result_word.resolve_node   <= ev_resolve;
      result_word.resolve_all    <= res_all;
      result_word.referee_winner <= winner_next;
    end
  end

  // checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    event_stall |-> (s1_valid && result_valid && result_stall))
    else $error("event stall without a held result");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> ((restart_counter - $past(restart_counter)) <= 32'd2))
    else $error("restart counter moved by more than two in one event");

  a_counter_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(restart_counter))
    else $error("restart counter changed without an event");

  a_resolve_online: assert property (@(posedge clk) disable iff (rst)
    (advance && ev_resolve != 5'd0) |-> (status == ST_ONLINE))
    else $error("resolve node raised while not online");

endmodule

`default_nettype wire
